@@ hw/rtl/jsu_pkg.sv @@
// Package for the JSON string unescape block: result kind codes, the
// result word struct and the character constants. No dependencies.
package jsu_pkg;

  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_QUOTE = 8'h22;
  localparam logic [7:0] CHR_BSLSH = 8'h5C;
  localparam logic [7:0] CHR_SPACE = 8'h20;
  localparam logic [7:0] CHR_SUBST = 8'h3F;
  localparam logic [15:0] CODE_LIMIT = 16'h0080;

  typedef struct packed {
    logic       valid;
    logic [7:0] data;
    logic [1:0] kind;
  } jsu_res_t;

endpackage

@@ hw/rtl/jsu_step.sv @@
// Decode step for the JSON string unescape block: mode state machine and
// \u accumulator, one byte per accepted word. Depends on jsu_pkg.
module jsu_step (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_fire,
  input  logic [7:0]       in_byte,
  output jsu_pkg::jsu_res_t res
);

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic [1:0]  hex_cnt_r, hex_cnt_nxt;
  logic [15:0] code_r, code_nxt;
  logic        code_ok_r, code_ok_nxt;

  logic        blank;
  logic        hex_hit;
  logic [3:0]  hex_val;
  logic        ok_acc;
  logic [15:0] code_acc;

  assign blank = (in_byte == jsu_pkg::CHR_SPACE) ||
                 ((in_byte >= 8'h09) && (in_byte <= 8'h0D));

  always_comb begin
    hex_hit = 1'b1;
    hex_val = 4'd0;
    if ((in_byte >= 8'h30) && (in_byte <= 8'h39)) begin
      hex_val = 4'(in_byte - 8'h30);
    end else if ((in_byte >= 8'h61) && (in_byte <= 8'h66)) begin
      hex_val = 4'(in_byte - 8'h57);
    end else if ((in_byte >= 8'h41) && (in_byte <= 8'h46)) begin
      hex_val = 4'(in_byte - 8'h37);
    end else begin
      hex_hit = 1'b0;
    end
  end

  assign ok_acc   = code_ok_r & hex_hit;
  assign code_acc = {code_r[11:0], hex_val};

  always_comb begin
    mode_nxt    = mode_r;
    hex_cnt_nxt = hex_cnt_r;
    code_nxt    = code_r;
    code_ok_nxt = code_ok_r;
    res.valid   = 1'b0;
    res.data    = jsu_pkg::CHR_NUL;
    res.kind    = jsu_pkg::KIND_CHAR;
    case (mode_r)
      MODE_IDLE: begin
        if (in_byte == jsu_pkg::CHR_QUOTE) begin
          mode_nxt = MODE_STR;
        end else if (!blank) begin
          res.valid = 1'b1;
          res.kind  = jsu_pkg::KIND_ERROR;
        end
      end
      MODE_STR: begin
        if (in_byte == jsu_pkg::CHR_NUL) begin
          mode_nxt  = MODE_IDLE;
          res.valid = 1'b1;
          res.kind  = jsu_pkg::KIND_ERROR;
        end else if (in_byte == jsu_pkg::CHR_QUOTE) begin
          mode_nxt  = MODE_IDLE;
          res.valid = 1'b1;
          res.kind  = jsu_pkg::KIND_CLOSE;
        end else if (in_byte == jsu_pkg::CHR_BSLSH) begin
          mode_nxt = MODE_ESC;
        end else begin
          res.valid = 1'b1;
          res.data  = in_byte;
        end
      end
      MODE_ESC: begin
        if (in_byte == jsu_pkg::CHR_NUL) begin
          mode_nxt  = MODE_IDLE;
          res.valid = 1'b1;
          res.kind  = jsu_pkg::KIND_ERROR;
        end else if (in_byte == 8'h75) begin
          mode_nxt    = MODE_HEX;
          hex_cnt_nxt = 2'd0;
          code_nxt    = 16'h0000;
          code_ok_nxt = 1'b1;
        end else begin
          mode_nxt  = MODE_STR;
          res.valid = 1'b1;
          case (in_byte)
            8'h62:   res.data = 8'h08;
            8'h66:   res.data = 8'h0C;
            8'h6E:   res.data = 8'h0A;
            8'h72:   res.data = 8'h0D;
            8'h74:   res.data = 8'h09;
            default: res.data = in_byte;
          endcase
        end
      end
      MODE_HEX: begin
        if (in_byte == jsu_pkg::CHR_NUL) begin
          mode_nxt    = MODE_IDLE;
          hex_cnt_nxt = 2'd0;
          res.valid   = 1'b1;
          res.kind    = jsu_pkg::KIND_ERROR;
        end else begin
          code_nxt    = code_acc;
          code_ok_nxt = ok_acc;
          if (hex_cnt_r == 2'd3) begin
            // fourth digit: give the code if all digits are hex and it is non-zero plain ASCII, else substitute
            hex_cnt_nxt = 2'd0;
            mode_nxt    = MODE_STR;
            res.valid   = 1'b1;
            if (ok_acc && (code_acc != 16'h0000) && (code_acc < jsu_pkg::CODE_LIMIT)) begin
              res.data = code_acc[7:0];
            end else begin
              res.data = jsu_pkg::CHR_SUBST;
            end
          end else begin
            hex_cnt_nxt = hex_cnt_r + 2'd1;
          end
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      hex_cnt_r <= 2'd0;
      code_r    <= 16'h0000;
      code_ok_r <= 1'b1;
    end else if (in_fire) begin
      mode_r    <= mode_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      code_r    <= code_nxt;
      code_ok_r <= code_ok_nxt;
    end
  end

endmodule

@@ hw/rtl/json_string_unescape.sv @@
// Top level of the JSON string unescape block: handshake and result register
// around the decode step. Depends on jsu_pkg and jsu_step.
//
// Usage:
//   Input channel in_valid/in_ready carries one text word (in_text_byte) per
//   transfer; a zero byte marks the end of the text. Outside a string
//   whitespace is skipped and an opening quote enters a string.
//   Result channel out_valid/out_ready carries out_byte and out_kind:
//   kind 0 a decoded character, 1 string closed, 2 error (out_byte is 0
//   for kinds 1 and 2). Bytes that cause no result (quotes opening a string,
//   whitespace outside strings, escape backslashes, the u of \u and \u digits
//   before the fourth) give no word. A result appears in the cycle after its
//   input word is accepted. One word is taken per cycle while the receiver
//   keeps up; in_ready is high whenever the single result register is empty
//   or being emptied. When the receiver stalls, the result is held and
//   in_ready drops until it is taken.
//   Reset (rst_n low, synchronous) empties the result register and returns
//   the decoder to idle outside any string.
module json_string_unescape (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_text_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] out_kind
);

  jsu_pkg::jsu_res_t res;
  logic              in_fire;
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic [1:0]        out_kind_r;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  jsu_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_text_byte),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res.valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload loads only with a new result word
  always_ff @(posedge clk) begin
    if (in_fire && res.valid) begin
      out_byte_r <= res.data;
      out_kind_r <= res.kind;
    end
  end

  assign out_valid = out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_kind  = out_kind_r;

endmodule

@@ hw/rtl/jsu_checker.sv @@
// Port-level checker for the JSON string unescape block, bound to the top
// level. Depends on jsu_pkg.
module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_text_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic [1:0] out_kind
);

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_kind))
    else $error("result word changed while stalled");

  a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind == jsu_pkg::KIND_CHAR) || (out_kind == jsu_pkg::KIND_CLOSE) ||
                  (out_kind == jsu_pkg::KIND_ERROR))
    else $error("undefined result kind");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != jsu_pkg::KIND_CHAR) |-> out_byte == 8'h00)
    else $error("status word with non-zero byte");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input stalled with result path free");

  // end of text gives an error whatever the mode
  a_nul_error: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_text_byte == 8'h00) |=>
      out_valid && (out_kind == jsu_pkg::KIND_ERROR))
    else $error("end of text gave no error");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_text_byte (in_text_byte),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_byte     (out_byte),
  .out_kind     (out_kind)
);
